/* rtl/lpd_pkg.sv */
// Shared types, codes and constants for the length prefix deframer.
`timescale 1ns / 1ps

package lpd_pkg;

	// Width of the assembled length prefix
	localparam int LENGTH_W = 32;
	// Width of the payload byte counter and the max payload register
	localparam int REM_W    = 32;
	// Common width for comparing a payload length against the limit
	localparam int CMP_W    = (LENGTH_W > REM_W) ? LENGTH_W : REM_W;

	// Input command codes
	typedef enum logic {
		CMD_BYTE  = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// Prefix size codes; the unused code is taken as four bytes
	typedef enum logic [1:0] {
		PSZ_1 = 2'd0,
		PSZ_2 = 2'd1,
		PSZ_4 = 2'd2
	} psz_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_PREFIX_SIZE   = 2'd0,
		REG_BIG_ENDIAN    = 2'd1,
		REG_MAX_PAYLOAD   = 2'd2,
		REG_COUNTS_PREFIX = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]       prefix_size_code;
		logic             big_endian;
		logic [REM_W-1:0] max_payload;
		logic             length_counts_prefix;
	} lpd_cfg_t;

	typedef struct packed {
		logic                in_payload;
		logic [2:0]          prefix_count;
		logic [LENGTH_W-1:0] length_accum;
		logic [REM_W-1:0]    remaining;
	} lpd_state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic       last;
	} lpd_result_t;

endpackage

/* rtl/length_prefix_deframer.sv */
// Top level of the length prefix deframer: input stage, state and result register.
`timescale 1ns / 1ps

// Splits a byte stream into frames led by a 1, 2 or 4 byte length prefix
// (MSB or LSB first). Payload bytes leave cut-through, one result word per
// byte, with last on the final byte; a zero length gives one empty-frame word
// and a bad header (shorter than the prefix when the length counts it, or
// above max_payload) gives one error word, after which the next byte starts a
// new prefix. A flush word drops any partial frame and gives no result.
// One word is accepted every cycle while the output is not stalled; a result
// word passes through the input register, then the result register, before it
// shows on the output. A stalled, full result register stalls the input. The
// single pass from the input register to the result register holds a 32-bit
// subtract followed by a 32-bit compare, which sets the clock.
module length_prefix_deframer (
	input  logic                     clk,
	input  logic                     arst_n,
	// input words
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     command,
	input  logic [7:0]               in_byte,
	// result words
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               kind,
	output logic [7:0]               payload_byte,
	output logic                     last,
	// configuration
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [lpd_pkg::REM_W-1:0] cfg_data
);
	import lpd_pkg::*;

	logic        valid_s1;
	logic        command_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	lpd_result_t res_s2;
	lpd_cfg_t    cfg_q;
	lpd_state_t  state_q;
	lpd_state_t  st_next;
	logic        res_valid;
	lpd_result_t res;
	logic        out_free;
	logic        advance;

	// Handshake
	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			byte_s1    <= in_byte;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prefix_size_code     <= PSZ_2;
			cfg_q.big_endian           <= 1'b1;
			cfg_q.max_payload          <= REM_W'(65535);
			cfg_q.length_counts_prefix <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PREFIX_SIZE:   cfg_q.prefix_size_code     <= cfg_data[1:0];
				REG_BIG_ENDIAN:    cfg_q.big_endian           <= cfg_data[0];
				REG_MAX_PAYLOAD:   cfg_q.max_payload          <= cfg_data;
				REG_COUNTS_PREFIX: cfg_q.length_counts_prefix <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Frame logic
	lpd_step u_step (
		.cfg       (cfg_q),
		.st        (state_q),
		.command   (command_s1),
		.in_byte   (byte_s1),
		.st_next   (st_next),
		.res_valid (res_valid),
		.res       (res)
	);

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= st_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign kind         = res_s2.kind;
	assign payload_byte = res_s2.payload_byte;
	assign last         = res_s2.last;

endmodule

/* rtl/lpd_step.sv */
// Per-word next-state and result logic of the length prefix deframer.
`timescale 1ns / 1ps

module lpd_step (
	input  lpd_pkg::lpd_cfg_t    cfg,
	input  lpd_pkg::lpd_state_t  st,
	input  logic                 command,
	input  logic [7:0]           in_byte,
	output lpd_pkg::lpd_state_t  st_next,
	output logic                 res_valid,
	output lpd_pkg::lpd_result_t res
);
	import lpd_pkg::*;

	logic [2:0]          nbytes;
	logic [2:0]          cnt_inc;
	logic [REM_W-1:0]    rem_dec;
	logic [LENGTH_W-1:0] accum_new;
	logic [LENGTH_W-1:0] frame_len;
	logic                too_short;
	logic                too_long;

	// Prefix length in bytes
	always_comb begin
		case (psz_t'(cfg.prefix_size_code))
			PSZ_1:   nbytes = 3'd1;
			PSZ_2:   nbytes = 3'd2;
			default: nbytes = 3'd4;
		endcase
	end

	// Prefix byte gather, MSB first shifts in, LSB first places by count
	always_comb begin
		if (cfg.big_endian) begin
			accum_new = LENGTH_W'({st.length_accum, in_byte});
		end else begin
			accum_new = st.length_accum
				| (LENGTH_W'(in_byte) << {st.prefix_count[1:0], 3'b000});
		end
	end

	assign cnt_inc = st.prefix_count + 3'd1;
	assign rem_dec = st.remaining - REM_W'(1);

	// Header checks on the completed prefix
	assign too_short = cfg.length_counts_prefix && (accum_new < LENGTH_W'(nbytes));
	assign frame_len = cfg.length_counts_prefix ? (accum_new - LENGTH_W'(nbytes))
	                                            : accum_new;
	assign too_long  = CMP_W'(frame_len) > CMP_W'(cfg.max_payload);

	// Main decision
	always_comb begin
		st_next          = st;
		res_valid        = 1'b0;
		res.kind         = KIND_BYTE;
		res.payload_byte = 8'd0;
		res.last         = 1'b0;
		if (cmd_t'(command) == CMD_FLUSH) begin
			st_next = '0;
		end else if (st.in_payload) begin
			// cut-through payload byte
			st_next.remaining = rem_dec;
			res_valid         = 1'b1;
			res.payload_byte  = in_byte;
			res.last          = (rem_dec == '0);
			if (rem_dec == '0) begin
				st_next.in_payload = 1'b0;
			end
		end else if (cnt_inc < nbytes) begin
			st_next.prefix_count = cnt_inc;
			st_next.length_accum = accum_new;
		end else begin
			// prefix complete
			st_next = '0;
			if (too_short || too_long) begin
				res_valid = 1'b1;
				res.kind  = KIND_ERROR;
			end else if (frame_len == '0) begin
				res_valid = 1'b1;
				res.kind  = KIND_EMPTY;
				res.last  = 1'b1;
			end else begin
				st_next.in_payload = 1'b1;
				st_next.remaining  = REM_W'(frame_len);
			end
		end
	end

endmodule

/* rtl/lpd_checker.sv */
// Port-level checks for the length prefix deframer, bound to the top level.
`timescale 1ns / 1ps

module lpd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [1:0]                kind,
	input logic [7:0]                payload_byte,
	input logic                      last
);
	import lpd_pkg::*;

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind)
			&& $stable(payload_byte) && $stable(last))
		else $error("result word changed while stalled");

	// Input is never stalled while the result register is empty
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	// Error words carry no byte and no last
	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> !last && payload_byte == 8'd0)
		else $error("error word with payload fields set");

	// Empty frame words close a frame and carry no byte
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EMPTY |-> last && payload_byte == 8'd0)
		else $error("empty frame word malformed");

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (.*);
